// File: rtl/tsr_pkg.sv
// tsr_pkg: shared types and constants of the triangle sample rasterizer
// no dependencies; used by tsr_ctrl, tsr_dpath and the top level
package tsr_pkg;

  localparam int unsigned CoordBits = 24;
  localparam int unsigned DiffBits  = CoordBits + 2;
  localparam int unsigned ProdBits  = 2 * DiffBits;
  localparam int unsigned EdgeBits  = ProdBits + 1;
  localparam int unsigned ScrBits   = 23;
  localparam int unsigned HitBits   = 24;

  // item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_LOADED = 2'd0;
  localparam logic [1:0] STATUS_TESTED = 2'd1;
  localparam logic [1:0] STATUS_NONE   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_FRAC   = 2'd0;
  localparam logic [1:0] REG_SUB    = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  // multiply sequence: six products, then a final slot to fold the last
  localparam logic [2:0] MUL_LAST = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SAMPLE,
    ST_MUL,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic       capture_vtx;
    logic       build_box;
    logic       idle_report;
    logic       sample;
    logic       mul_en;
    logic [2:0] mul_idx;
    logic       finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic walk_active;
  } ctl_stat_t;

endpackage

// File: rtl/tsr_ctrl.sv
// tsr_ctrl: sequencing state machine of the rasterizer
// depends on tsr_pkg; drives tsr_dpath through ctl_cmd_t
module tsr_ctrl import tsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      cmd_i,
  input  ctl_stat_t stat_i,
  output ctl_cmd_t  ctl_o,
  output logic      busy_o
);

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ctl_o   = '0;
    ctl_o.mul_idx = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (cmd_i == CMD_LOAD) begin
            ctl_o.capture_vtx = 1'b1;
            state_d = ST_LOAD;
          end else if (stat_i.walk_active) begin
            state_d = ST_SAMPLE;
          end else begin
            ctl_o.idle_report = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        ctl_o.build_box = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SAMPLE: begin
        ctl_o.sample = 1'b1;
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        ctl_o.mul_en = 1'b1;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == MUL_LAST) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        ctl_o.finish = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// File: rtl/tsr_dpath.sv
// tsr_dpath: vertex store, box walk, jitter, shared edge multiplier, results
// depends on tsr_pkg; commanded by tsr_ctrl
module tsr_dpath import tsr_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ctl_cmd_t                    ctl_i,
  output ctl_stat_t                   stat_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [ScrBits-1:0]          cfg_data_i,
  input  logic signed [CoordBits-1:0] v0_x_i,
  input  logic signed [CoordBits-1:0] v0_y_i,
  input  logic signed [CoordBits-1:0] v1_x_i,
  input  logic signed [CoordBits-1:0] v1_y_i,
  input  logic signed [CoordBits-1:0] v2_x_i,
  input  logic signed [CoordBits-1:0] v2_y_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic                        hit_o,
  output logic [14:0]                 pixel_x_o,
  output logic [14:0]                 pixel_y_o,
  output logic [2:0]                  sub_x_o,
  output logic [2:0]                  sub_y_o,
  output logic                        last_o,
  output logic [HitBits-1:0]          hit_tally_o
);

  // configuration registers
  logic [3:0]         frac_q;
  logic [1:0]         sub_q;
  logic [ScrBits-1:0] scr_w_q, scr_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q  <= 4'd10;
      sub_q   <= 2'd2;
      scr_w_q <= ScrBits'(1048576);
      scr_h_q <= ScrBits'(1048576);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAC:   frac_q  <= cfg_data_i[3:0];
        REG_SUB:    sub_q   <= cfg_data_i[1:0];
        REG_WIDTH:  scr_w_q <= cfg_data_i;
        REG_HEIGHT: scr_h_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // grid shift and step
  logic [3:0]  g;
  logic [15:0] step;
  assign g    = (frac_q > {2'b00, sub_q}) ? (frac_q - {2'b00, sub_q}) : 4'd0;
  assign step = 16'd1 << g;

  // vertex store
  logic signed [CoordBits-1:0] vx_q [3];
  logic signed [CoordBits-1:0] vy_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
      end
    end else if (ctl_i.capture_vtx) begin
      vx_q[0] <= v0_x_i; vy_q[0] <= v0_y_i;
      vx_q[1] <= v1_x_i; vy_q[1] <= v1_y_i;
      vx_q[2] <= v2_x_i; vy_q[2] <= v2_y_i;
    end
  end

  // bounding box: min/max, floor to grid, clip
  logic signed [CoordBits-1:0] mnx, mxx, mny, mxy;
  logic signed [CoordBits-1:0] gmask;
  logic signed [CoordBits-1:0] flx, fux, fly, fuy;
  logic signed [CoordBits-1:0] blx, bux, bly, buy;
  logic                        box_ok;

  always_comb begin
    mnx = vx_q[0]; mxx = vx_q[0];
    mny = vy_q[0]; mxy = vy_q[0];
    for (int i = 1; i < 3; i++) begin
      if (vx_q[i] < mnx) mnx = vx_q[i];
      if (vx_q[i] > mxx) mxx = vx_q[i];
      if (vy_q[i] < mny) mny = vy_q[i];
      if (vy_q[i] > mxy) mxy = vy_q[i];
    end
    gmask = ~((CoordBits'(1) << g) - CoordBits'(1));
    flx = mnx & gmask; fux = mxx & gmask;
    fly = mny & gmask; fuy = mxy & gmask;
    blx = flx[CoordBits-1] ? '0 : flx;
    bly = fly[CoordBits-1] ? '0 : fly;
    bux = (fux > $signed({1'b0, scr_w_q})) ? $signed({1'b0, scr_w_q}) : fux;
    buy = (fuy > $signed({1'b0, scr_h_q})) ? $signed({1'b0, scr_h_q}) : fuy;
    box_ok = (blx <= bux) && (bly <= buy);
  end

  // walk state
  logic signed [CoordBits-1:0] lx_q, ly_q, ux_q, uy_q, cx_q, cy_q;
  logic                        walk_q;
  logic [HitBits-1:0]          hits_q;
  assign stat_o.walk_active = walk_q;

  // jittered sample and vertex differences
  logic [7:0]                 jmask, jx, jy;
  logic signed [DiffBits-1:0] sx, sy;
  logic signed [DiffBits-1:0] dx_q [3];
  logic signed [DiffBits-1:0] dy_q [3];

  assign jmask = 8'hff >> sub_q;
  assign jx = (cx_q[11:4] ^ cy_q[23:16]) & jmask;
  assign jy = (cy_q[11:4] ^ cx_q[23:16]) & jmask;
  assign sx = DiffBits'(cx_q) + $signed({16'd0, jx, 2'b00});
  assign sy = DiffBits'(cy_q) + $signed({16'd0, jy, 2'b00});

  always_ff @(posedge clk_i) begin
    if (ctl_i.sample) begin
      for (int i = 0; i < 3; i++) begin
        dx_q[i] <= DiffBits'(vx_q[i]) - sx;
        dy_q[i] <= DiffBits'(vy_q[i]) - sy;
      end
    end
  end

  // shared multiplier: operand select per sequence slot
  logic signed [DiffBits-1:0] op_a, op_b;
  always_comb begin
    unique case (ctl_i.mul_idx)
      3'd0:    begin op_a = dx_q[0]; op_b = dy_q[1]; end
      3'd1:    begin op_a = dx_q[1]; op_b = dy_q[0]; end
      3'd2:    begin op_a = dx_q[1]; op_b = dy_q[2]; end
      3'd3:    begin op_a = dx_q[2]; op_b = dy_q[1]; end
      3'd4:    begin op_a = dx_q[2]; op_b = dy_q[0]; end
      3'd5:    begin op_a = dx_q[0]; op_b = dy_q[2]; end
      default: begin op_a = '0;      op_b = '0;      end
    endcase
  end

  logic signed [ProdBits-1:0] prod_q, first_q;
  logic signed [EdgeBits-1:0] edge_d;
  logic [2:0]                 prev_idx;
  logic [2:0]                 inside_q;

  assign prev_idx = ctl_i.mul_idx - 3'd1;
  assign edge_d   = EdgeBits'(first_q) - EdgeBits'(prod_q);

  // product register and edge folding of the product from the previous slot
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= op_a * op_b;
      if (ctl_i.mul_idx != 3'd0) begin
        if (!prev_idx[0]) begin
          first_q <= prod_q;
        end else begin
          unique case (prev_idx[2:1])
            2'd0:    inside_q[0] <= edge_d[EdgeBits-1] || (edge_d == '0);
            2'd1:    inside_q[1] <= edge_d[EdgeBits-1];
            default: inside_q[2] <= edge_d[EdgeBits-1] || (edge_d == '0);
          endcase
        end
      end
    end
  end

  // cursor advance
  logic signed [DiffBits-1:0] ny, nx;
  logic                       hit;
  logic [CoordBits-1:0]       fmask;
  assign ny    = DiffBits'(cy_q) + $signed({10'd0, step});
  assign nx    = DiffBits'(cx_q) + $signed({10'd0, step});
  assign hit   = &inside_q;
  assign fmask = (CoordBits'(1) << frac_q) - CoordBits'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= '0; ly_q <= '0; ux_q <= '0; uy_q <= '0;
      cx_q <= '0; cy_q <= '0;
      walk_q <= 1'b0;
      hits_q <= '0;
    end else if (ctl_i.build_box) begin
      lx_q <= blx; ly_q <= bly; ux_q <= bux; uy_q <= buy;
      cx_q <= blx; cy_q <= bly;
      walk_q <= box_ok;
      hits_q <= '0;
    end else if (ctl_i.finish) begin
      if (hit && (hits_q != '1)) hits_q <= hits_q + 1'b1;
      if (ny <= DiffBits'(uy_q)) begin
        cy_q <= CoordBits'(ny);
      end else if (nx <= DiffBits'(ux_q)) begin
        cy_q <= ly_q;
        cx_q <= CoordBits'(nx);
      end else begin
        walk_q <= 1'b0;
      end
    end
  end

  // result register
  logic                 done_q;
  logic [1:0]           status_q;
  logic                 hit_q, last_q;
  logic [14:0]          px_q, py_q;
  logic [2:0]           sbx_q, sby_q;
  logic [HitBits-1:0]   cnt_q;
  logic [CoordBits-1:0] pxs, pys, sbxs, sbys;

  assign pxs  = cx_q >> frac_q;
  assign pys  = cy_q >> frac_q;
  assign sbxs = (cx_q & fmask) >> g;
  assign sbys = (cy_q & fmask) >> g;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.build_box || ctl_i.idle_report || ctl_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.build_box) begin
      status_q <= STATUS_LOADED;
      hit_q <= 1'b0; px_q <= '0; py_q <= '0; sbx_q <= '0; sby_q <= '0;
      last_q <= !box_ok;
      cnt_q  <= '0;
    end else if (ctl_i.idle_report) begin
      status_q <= STATUS_NONE;
      hit_q <= 1'b0; px_q <= '0; py_q <= '0; sbx_q <= '0; sby_q <= '0;
      last_q <= 1'b0;
      cnt_q  <= hits_q;
    end else if (ctl_i.finish) begin
      status_q <= STATUS_TESTED;
      hit_q  <= hit;
      px_q   <= pxs[14:0];
      py_q   <= pys[14:0];
      sbx_q  <= sbxs[2:0];
      sby_q  <= sbys[2:0];
      last_q <= !((ny <= DiffBits'(uy_q)) || (nx <= DiffBits'(ux_q)));
      cnt_q  <= (hit && (hits_q != '1)) ? hits_q + 1'b1 : hits_q;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign hit_o       = hit_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign sub_x_o     = sbx_q;
  assign sub_y_o     = sby_q;
  assign last_o      = last_q;
  assign hit_tally_o = cnt_q;

endmodule

// File: rtl/triangle_sample_rasterizer_unit.sv
// triangle_sample_rasterizer_unit: top level, controller plus datapath
// depends on tsr_pkg, tsr_ctrl, tsr_dpath
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------
//  item in   | start_i, busy_o           | cmd_i, v0_x_i .. v2_y_i
//  config    | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//  result    | done_o (one-cycle strobe) | status_o .. hit_tally_o
//
// load: result registered after vertex capture and box build
// step with a walk pending: sample, the multiply slots of the one shared signed
//   multiplier of DiffBits-wide operands for all edge functions, finish
// step with nothing pending: result in the cycle after the transfer, busy stays low
// reset clears control and walk state; config registers take their defaults
// results cannot be stalled; config writes are always ready
module triangle_sample_rasterizer_unit import tsr_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        cmd_i,
  input  logic signed [CoordBits-1:0] v0_x_i,
  input  logic signed [CoordBits-1:0] v0_y_i,
  input  logic signed [CoordBits-1:0] v1_x_i,
  input  logic signed [CoordBits-1:0] v1_y_i,
  input  logic signed [CoordBits-1:0] v2_x_i,
  input  logic signed [CoordBits-1:0] v2_y_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [ScrBits-1:0]          cfg_data_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic                        hit_o,
  output logic [14:0]                 pixel_x_o,
  output logic [14:0]                 pixel_y_o,
  output logic [2:0]                  sub_x_o,
  output logic [2:0]                  sub_y_o,
  output logic                        last_o,
  output logic [HitBits-1:0]          hit_tally_o
);

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  assign cfg_ready_o = 1'b1;

  tsr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .stat_i  (stat),
    .ctl_o   (ctl),
    .busy_o  (busy_o)
  );

  tsr_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .v0_x_i      (v0_x_i),
    .v0_y_i      (v0_y_i),
    .v1_x_i      (v1_x_i),
    .v1_y_i      (v1_y_i),
    .v2_x_i      (v2_x_i),
    .v2_y_i      (v2_y_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .hit_o       (hit_o),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .sub_x_o     (sub_x_o),
    .sub_y_o     (sub_y_o),
    .last_o      (last_o),
    .hit_tally_o (hit_tally_o)
  );

  // a load transfer always occupies the block for the box build
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i == CMD_LOAD) |=> busy_o)
    else $error("load did not enter box build");

  // load results carry no hit and a cleared count
  a_load_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_LOADED) |-> (!hit_o && hit_tally_o == '0))
    else $error("load result not cleared");

  // a tested sample is reported only as the controller returns to idle
  a_tested_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_TESTED) |-> !busy_o)
    else $error("sample result while busy");

  // status code is always a defined one
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == STATUS_LOADED || status_o == STATUS_TESTED ||
                status_o == STATUS_NONE))
    else $error("undefined status code");

endmodule

// File: sim/testbench.sv
// testbench: self-checking bench for triangle_sample_rasterizer_unit
// depends on tsr_pkg and the rtl of triangle_sample_rasterizer_unit
module testbench;
  import tsr_pkg::*;

  typedef struct {
    logic                        cmd;
    logic signed [CoordBits-1:0] vtx [6];
  } tri_item_t;

  typedef struct {
    logic [1:0]         status;
    logic               hit;
    logic [14:0]        px;
    logic [14:0]        py;
    logic [2:0]         sx;
    logic [2:0]         sy;
    logic               last;
    logic [HitBits-1:0] cnt;
  } sample_res_t;

  localparam int unsigned IdleLimit = 4000;
  localparam longint HitMax = 64'hFFFFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic cmd_i = 1'b0;
  logic signed [CoordBits-1:0] v0_x_i = '0, v0_y_i = '0, v1_x_i = '0;
  logic signed [CoordBits-1:0] v1_y_i = '0, v2_x_i = '0, v2_y_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [1:0] cfg_index_i = REG_FRAC;
  logic [ScrBits-1:0] cfg_data_i = '0;
  logic busy_o, cfg_ready_o, done_o, hit_o, last_o;
  logic [1:0] status_o;
  logic [14:0] pixel_x_o, pixel_y_o;
  logic [2:0] sub_x_o, sub_y_o;
  logic [HitBits-1:0] hit_tally_o;

  triangle_sample_rasterizer_unit DUT (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of configuration and walk state
  logic [3:0] m_frac = 4'd10;
  logic [1:0] m_sub = 2'd2;
  longint m_width = 1048576, m_height = 1048576;
  longint m_vtx [6];
  longint m_lx, m_ly, m_ux, m_uy, m_cx, m_cy;
  logic m_walk = 1'b0;
  longint m_hits = 0;

  tri_item_t   item_q [$];
  sample_res_t sample_exp_q [$];
  int unsigned fail_cnt = 0;
  logic drv_pending = 1'b0;
  logic burst_mode = 1'b0;

  function automatic int unsigned grid_shift();
    return (m_frac > m_sub) ? int'(m_frac - m_sub) : 0;
  endfunction

  function automatic longint floor_grid(longint v, int unsigned g);
    return v - (v & ((64'sd1 <<< g) - 1));
  endfunction

  // per-sample jitter from the byte fold of the packed coordinate word
  function automatic longint jitter(longint a, longint b);
    logic [63:0] lo, hi, w;
    logic [7:0] h;
    lo = (64'(a) >> 4) & 64'hFF_FFFF_FFFF;
    hi = (64'(b) >> 4) & 64'hFF_FFFF_FFFF;
    w = ((hi << 20) | lo) & 64'hFF_FFFF_FFFF;
    h = (w[7:0] ^ w[39:32]) & (8'hFF >> m_sub);
    return longint'(h) << 2;
  endfunction

  function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by);
    return ax * by - bx * ay;
  endfunction

  // compute the result of one accepted item and update walk state
  function automatic sample_res_t rasterize(tri_item_t it);
    sample_res_t r;
    int unsigned g;
    longint stp, sxj, syj, ax, ay, bx, by, qx, qy;
    logic hit;
    r = '{status: STATUS_LOADED, hit: 0, px: 0, py: 0, sx: 0, sy: 0, last: 0, cnt: 0};
    g = grid_shift();
    if (it.cmd == CMD_LOAD) begin
      for (int i = 0; i < 6; i++) m_vtx[i] = longint'(it.vtx[i]);
      m_lx = m_vtx[0]; m_ux = m_vtx[0]; m_ly = m_vtx[1]; m_uy = m_vtx[1];
      for (int i = 1; i < 3; i++) begin
        if (m_vtx[2*i] < m_lx) m_lx = m_vtx[2*i];
        if (m_vtx[2*i] > m_ux) m_ux = m_vtx[2*i];
        if (m_vtx[2*i+1] < m_ly) m_ly = m_vtx[2*i+1];
        if (m_vtx[2*i+1] > m_uy) m_uy = m_vtx[2*i+1];
      end
      m_lx = floor_grid(m_lx, g); m_ly = floor_grid(m_ly, g);
      m_ux = floor_grid(m_ux, g); m_uy = floor_grid(m_uy, g);
      if (m_ux > m_width) m_ux = m_width;
      if (m_uy > m_height) m_uy = m_height;
      if (m_lx < 0) m_lx = 0;
      if (m_ly < 0) m_ly = 0;
      m_cx = m_lx; m_cy = m_ly; m_hits = 0;
      m_walk = (m_lx <= m_ux) && (m_ly <= m_uy);
      r.last = !m_walk;
      return r;
    end
    if (!m_walk) begin
      r.status = STATUS_NONE;
      r.cnt = m_hits[HitBits-1:0];
      return r;
    end
    stp = 64'sd1 <<< g;
    sxj = m_cx + jitter(m_cx, m_cy);
    syj = m_cy + jitter(m_cy, m_cx);
    ax = m_vtx[0] - sxj; ay = m_vtx[1] - syj;
    bx = m_vtx[2] - sxj; by = m_vtx[3] - syj;
    qx = m_vtx[4] - sxj; qy = m_vtx[5] - syj;
    hit = edge_fn(ax, ay, bx, by) <= 0 && edge_fn(bx, by, qx, qy) < 0 &&
          edge_fn(qx, qy, ax, ay) <= 0;
    if (hit && m_hits < HitMax) m_hits++;
    r.status = STATUS_TESTED;
    r.hit = hit;
    r.px = 15'(64'(m_cx) >> m_frac);
    r.py = 15'(64'(m_cy) >> m_frac);
    r.sx = 3'((64'(m_cx) & ((64'd1 << m_frac) - 1)) >> g);
    r.sy = 3'((64'(m_cy) & ((64'd1 << m_frac) - 1)) >> g);
    // walk order: y inner, x outer
    if (m_cy + stp <= m_uy) begin
      m_cy += stp;
    end else if (m_cx + stp <= m_ux) begin
      m_cy = m_ly;
      m_cx += stp;
    end else begin
      r.last = 1'b1;
      m_walk = 1'b0;
    end
    r.cnt = m_hits[HitBits-1:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_cnt++;
  endtask

  // driver: one item in flight, random gap before each
  int unsigned gap_cnt = 0;
  tri_item_t cur_item;
  always @(posedge clk_i) begin
    logic pend;
    pend = drv_pending;
    if (start_i && !busy_o) begin
      sample_exp_q.push_back(rasterize(cur_item));
      pend = 1'b0;
      if ($urandom_range(0, 15) == 0) burst_mode = !burst_mode;
      gap_cnt = burst_mode ? 0 : $urandom_range(0, 18);
    end
    if (!pend && gap_cnt > 0) begin
      gap_cnt--;
    end else if (!pend && item_q.size() > 0) begin
      cur_item = item_q.pop_front();
      pend = 1'b1;
      cmd_i <= cur_item.cmd;
      v0_x_i <= cur_item.vtx[0]; v0_y_i <= cur_item.vtx[1];
      v1_x_i <= cur_item.vtx[2]; v1_y_i <= cur_item.vtx[3];
      v2_x_i <= cur_item.vtx[4]; v2_y_i <= cur_item.vtx[5];
    end
    drv_pending = pend;
    start_i <= pend;
  end

  // monitor and watchdog
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    sample_res_t e;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("triangle_sample_rasterizer_unit verification failed");
        $finish;
      end
    end
    if (rst_ni && done_o) begin
      if (sample_exp_q.size() == 0) begin
        report("unexpected result", 32'(status_o), 0);
      end else begin
        e = sample_exp_q.pop_front();
        if (status_o !== e.status) report("status", 32'(status_o), 32'(e.status));
        if (hit_o !== e.hit) report("hit", 32'(hit_o), 32'(e.hit));
        if (pixel_x_o !== e.px) report("pixel_x", 32'(pixel_x_o), 32'(e.px));
        if (pixel_y_o !== e.py) report("pixel_y", 32'(pixel_y_o), 32'(e.py));
        if (sub_x_o !== e.sx) report("sub_x", 32'(sub_x_o), 32'(e.sx));
        if (sub_y_o !== e.sy) report("sub_y", 32'(sub_y_o), 32'(e.sy));
        if (last_o !== e.last) report("last", 32'(last_o), 32'(e.last));
        if (hit_tally_o !== e.cnt) report("hit_tally", 32'(hit_tally_o), 32'(e.cnt));
      end
    end
  end

  task automatic add_load(input longint x0, y0, x1, y1, x2, y2);
    tri_item_t it;
    it.cmd = CMD_LOAD;
    it.vtx[0] = x0[23:0]; it.vtx[1] = y0[23:0]; it.vtx[2] = x1[23:0];
    it.vtx[3] = y1[23:0]; it.vtx[4] = x2[23:0]; it.vtx[5] = y2[23:0];
    item_q.push_back(it);
  endtask

  task automatic add_steps(input int n);
    tri_item_t it;
    it.cmd = CMD_STEP;
    for (int i = 0; i < 6; i++) it.vtx[i] = 24'($urandom);
    repeat (n) item_q.push_back(it);
  endtask

  // wait for the block to drain, then leave room for a late result
  task automatic drain();
    while (item_q.size() > 0 || drv_pending || sample_exp_q.size() > 0) @(posedge clk_i);
    repeat (14) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [ScrBits-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_FRAC:   m_frac = val[3:0];
      REG_SUB:    m_sub = val[1:0];
      REG_WIDTH:  m_width = longint'(val);
      REG_HEIGHT: m_height = longint'(val);
      default: ;
    endcase
  endtask

  // random phase: mostly well-formed load-and-walk sequences, some noise
  task automatic random_phase(input int n_items);
    longint stp, cx, cy, span, cmax;
    int n;
    n = 0;
    stp = 64'sd1 <<< grid_shift();
    cmax = (m_width < 8300000) ? m_width : 8300000;
    while (n < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) add_load($signed(24'($urandom)), $signed(24'($urandom)),
                                           $signed(24'($urandom)), $signed(24'($urandom)),
                                           $signed(24'($urandom)), $signed(24'($urandom)));
        else add_steps(1);
        add_steps($urandom_range(0, 3));
        n += 3;
      end else begin
        span = stp * $urandom_range(1, 4);
        cx = longint'($urandom_range(0, 32'(cmax))) + $urandom_range(0, 40) - 20;
        cy = longint'($urandom_range(0, 32'(cmax))) + $urandom_range(0, 40) - 20;
        add_load(cx + $urandom_range(0, 32'(2*span)) - span,
                 cy + $urandom_range(0, 32'(2*span)) - span,
                 cx + $urandom_range(0, 32'(2*span)) - span,
                 cy + $urandom_range(0, 32'(2*span)) - span,
                 cx + $urandom_range(0, 32'(2*span)) - span,
                 cy + $urandom_range(0, 32'(2*span)) - span);
        n += 1 + 30;
        add_steps($urandom_range(1, 60));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset configuration
    add_steps(2);                                         // nothing pending
    add_load(0, 0, 0, 0, 0, 0);                           // one sample at the origin
    add_steps(2);
    add_load(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608);
    add_load(8388607, 8388607, 8388607, 8388607, 8388607, 8388607); // off screen
    add_steps(1);
    add_load(1000, 1000, 3000, 1000, 1000, 3000);         // one winding
    add_steps(6);
    add_load(1000, 1000, 1000, 3000, 3000, 1000);         // reversed winding
    add_steps(3);
    add_load(-8388608, 8388607, 512, -300, 8388607, -8388608); // load mid walk
    add_steps(2);
    add_load(600, 600, 300, 300, 800, 200);
    add_steps(1);
    drain();
    random_phase(150);
    drain();

    // extremes: eight fraction bits, no subsamples, widest screen
    write_reg(REG_FRAC, 23'd8);
    write_reg(REG_SUB, 23'd0);
    write_reg(REG_WIDTH, 23'd8388607);
    write_reg(REG_HEIGHT, 23'd8388607);
    add_load(8388352, 8388352, 8388607, 8388607, 8388352, 8388607);
    add_steps(6);
    random_phase(150);
    drain();

    // coarse fraction, most subsamples, small screen
    write_reg(REG_FRAC, 23'd12);
    write_reg(REG_SUB, 23'd3);
    write_reg(REG_WIDTH, 23'd65536);
    write_reg(REG_HEIGHT, 23'd40000);
    random_phase(150);
    drain();

    // subsample bits above fraction bits
    write_reg(REG_FRAC, 23'd2);
    write_reg(REG_SUB, 23'd3);
    write_reg(REG_WIDTH, 23'd4000);
    write_reg(REG_HEIGHT, 23'd3000);
    random_phase(150);
    drain();

    // zero-size screen
    write_reg(REG_FRAC, 23'd15);
    write_reg(REG_SUB, 23'd1);
    write_reg(REG_WIDTH, 23'd0);
    write_reg(REG_HEIGHT, 23'd0);
    random_phase(60);
    drain();

    write_reg(REG_FRAC, 23'd10);
    write_reg(REG_SUB, 23'd2);
    write_reg(REG_WIDTH, 23'd1048576);
    write_reg(REG_HEIGHT, 23'd2000000);
    random_phase(150);
    drain();

    if (fail_cnt == 0) begin
      $display("triangle_sample_rasterizer_unit verification clean");
    end else begin
      $display("triangle_sample_rasterizer_unit verification failed");
    end
    $finish;
  end

endmodule

// File: triangle_sample_rasterizer_unit.f
rtl/tsr_pkg.sv
rtl/tsr_ctrl.sv
rtl/tsr_dpath.sv
rtl/triangle_sample_rasterizer_unit.sv
sim/testbench.sv
